>>> design/wsp_pkg.sv
`timescale 1ns / 1ps

package wsp_pkg;

  // Default depth of the delta window.
  localparam int unsigned WINDOW_DEF = 8;

  // Field and register widths.
  localparam int unsigned DELTA_W   = 12;
  localparam int unsigned SUM_W     = 16;
  localparam int unsigned ERR_W     = 17;
  localparam int unsigned INTEG_W   = 15;
  localparam int unsigned ACC_W     = 18;
  localparam int unsigned GAIN_W    = 8;
  localparam int unsigned POWER_W   = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 16;

  // Product and accumulator widths.
  localparam int unsigned PPROD_W = 26;
  localparam int unsigned DPROD_W = 21;
  localparam int unsigned IPROD_W = 24;
  localparam int unsigned PD_W    = 27;
  localparam int unsigned TOTAL_W = 28;

  localparam int unsigned FRAC_SHIFT  = 7;
  localparam int signed   INTEG_LIMIT = 16256;
  localparam int signed   POWER_LIMIT = 127;

  localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 8'd15;
  localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 8'd1;
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 8'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN  = 3'd0,
    REG_INTEG_GAIN = 3'd1,
    REG_DERIV_GAIN = 3'd2,
    REG_TARGET_SUM = 3'd3,
    REG_BYPASS     = 3'd4
  } cfg_reg_e;

endpackage

>>> design/windowed_speed_pid.sv
`timescale 1ns / 1ps
// Path: an accepted delta beat moves through the stage registers to the output register.
// Throughput: one delta beat per cycle, sustained unless out_ready_i holds back a full
// pipeline; the delta ring is a one-port-write, one-port-read memory, and the running
// sum and the integrator are each read and rewritten in the same cycle.
// Reset (rst_ni low, asynchronous): ring entries read as zero, index, sum and integrator
// clear, gains return to 15/1/0, target to 0, bypass off, and the pipeline empties.
module windowed_speed_pid #(
  parameter int unsigned WINDOW = wsp_pkg::WINDOW_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Configuration write port.
  input  logic                                   cfg_we_i,
  input  logic [wsp_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [wsp_pkg::CFG_DAT_W-1:0]          cfg_data_i,
  // Delta input channel.
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [wsp_pkg::DELTA_W-1:0]     encoder_delta_i,
  // Power output channel.
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [wsp_pkg::POWER_W-1:0]     motor_power_o,
  output logic signed [wsp_pkg::SUM_W-1:0]       window_sum_o
);

  import wsp_pkg::*;

  localparam int unsigned IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW - 1);

  localparam logic signed [ACC_W-1:0] ACC_HI = ACC_W'(INTEG_LIMIT);
  localparam logic signed [ACC_W-1:0] ACC_LO = -ACC_W'(INTEG_LIMIT);
  localparam logic signed [TOTAL_W-FRAC_SHIFT-1:0] PWR_HI = (TOTAL_W-FRAC_SHIFT)'(POWER_LIMIT);
  localparam logic signed [TOTAL_W-FRAC_SHIFT-1:0] PWR_LO = -(TOTAL_W-FRAC_SHIFT)'(POWER_LIMIT);

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes must arrive only while the pipeline is empty;
  // the block does not enforce this, and the stages read these directly.
  // ---------------------------------------------------------------------------
  logic [GAIN_W-1:0]       prop_gain_q, integ_gain_q, deriv_gain_q;
  logic signed [SUM_W-1:0] target_q;
  logic                    bypass_q;
  logic                    integ_clr;

  assign integ_clr = cfg_we_i && (cfg_idx_i == REG_TARGET_SUM);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q  <= PROP_GAIN_RST;
      integ_gain_q <= INTEG_GAIN_RST;
      deriv_gain_q <= DERIV_GAIN_RST;
      target_q     <= '0;
      bypass_q     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_PROP_GAIN:  prop_gain_q  <= cfg_data_i[GAIN_W-1:0];
        REG_INTEG_GAIN: integ_gain_q <= cfg_data_i[GAIN_W-1:0];
        REG_DERIV_GAIN: deriv_gain_q <= cfg_data_i[GAIN_W-1:0];
        REG_TARGET_SUM: target_q     <= $signed(cfg_data_i[SUM_W-1:0]);
        REG_BYPASS:     bypass_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage handshake. Each stage moves on when the one after it is empty or
  // moving, so bubbles collapse and a full output register stalls only what
  // sits behind it.
  // ---------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q, v5_q, vo_q;
  logic en1, en2, en3, en4, en5, en_o;
  logic in_fire, fire1, fire3;

  assign en_o = !vo_q || out_ready_i;
  assign en5  = !v5_q || en_o;
  assign en4  = !v4_q || en5;
  assign en3  = !v3_q || en4;
  assign en2  = !v2_q || en3;
  assign en1  = !v1_q || en2;

  assign in_ready_o = en1;
  assign in_fire    = in_valid_i && en1;
  assign fire1      = v1_q && en2;
  assign fire3      = v3_q && en4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en1)  v1_q <= in_valid_i;
      // A bypassed beat still updates the ring and the sum, then leaves here.
      if (en2)  v2_q <= v1_q && !bypass_q;
      if (en3)  v3_q <= v2_q;
      if (en4)  v4_q <= v3_q;
      if (en5)  v5_q <= v4_q;
      if (en_o) vo_q <= v5_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: advance the ring pointer and read the entry about to be replaced.
  // ---------------------------------------------------------------------------
  logic [IDX_W-1:0] idx_q, idx_nxt, idx1_q;

  assign idx_nxt = (idx_q == IDX_LAST) ? '0 : idx_q + IDX_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (in_fire) begin
      idx_q <= idx_nxt;
    end
  end

  // The ring itself. Entries never written read as zero through their valid bit.
  // The entry read for one beat is written back before the same entry can be
  // read again, since a beat WINDOW later cannot enter until this one has left
  // stage 1, so no forwarding path is needed.
  logic signed [DELTA_W-1:0] ring_mem [WINDOW];
  logic [WINDOW-1:0]         ring_vld_q;
  logic signed [DELTA_W-1:0] rdata1_q, delta1_q;
  logic                      rvld1_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rdata1_q <= ring_mem[idx_nxt];
      rvld1_q  <= ring_vld_q[idx_nxt];
      delta1_q <= encoder_delta_i;
      idx1_q   <= idx_nxt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire1) begin
      ring_mem[idx1_q] <= delta1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_vld_q <= '0;
    end else if (fire1) begin
      ring_vld_q[idx1_q] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: running sum, minus the oldest delta and plus the newest, 16-bit wrap.
  // ---------------------------------------------------------------------------
  logic signed [SUM_W-1:0]   sum_q, sum_new, sum2_q;
  logic signed [DELTA_W-1:0] old1, delta2_q;

  assign old1    = rvld1_q ? rdata1_q : '0;
  assign sum_new = sum_q - SUM_W'(old1) + SUM_W'(delta1_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (fire1) begin
      sum_q <= sum_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      sum2_q   <= sum_new;
      delta2_q <= delta1_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: error at full 17-bit precision, window sum minus target.
  // ---------------------------------------------------------------------------
  logic signed [ERR_W-1:0]   err3_q;
  logic signed [SUM_W-1:0]   sum3_q;
  logic signed [DELTA_W-1:0] delta3_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      err3_q   <= ERR_W'(sum2_q) - ERR_W'(target_q);
      sum3_q   <= sum2_q;
      delta3_q <= delta2_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: saturating integrator update, proportional and derivative products.
  // ---------------------------------------------------------------------------
  logic signed [INTEG_W-1:0] integ_q, integ_sat, integ4_q;
  logic signed [ACC_W-1:0]   acc;
  logic signed [PPROD_W-1:0] pprod4_q;
  logic signed [DPROD_W-1:0] dprod4_q;
  logic signed [SUM_W-1:0]   sum4_q;

  assign acc = ACC_W'(integ_q) + ACC_W'(err3_q);

  always_comb begin
    if (acc > ACC_HI) begin
      integ_sat = INTEG_W'(ACC_HI);
    end else if (acc < ACC_LO) begin
      integ_sat = INTEG_W'(ACC_LO);
    end else begin
      integ_sat = acc[INTEG_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
    end else if (integ_clr) begin
      integ_q <= '0;
    end else if (fire3) begin
      integ_q <= integ_sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      integ4_q <= integ_sat;
      pprod4_q <= $signed({1'b0, prop_gain_q}) * err3_q;
      dprod4_q <= $signed({1'b0, deriv_gain_q}) * delta3_q;
      sum4_q   <= sum3_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: integral product and partial sum of the other two terms.
  // ---------------------------------------------------------------------------
  logic signed [IPROD_W-1:0] iprod5_q;
  logic signed [PD_W-1:0]    pd5_q;
  logic signed [SUM_W-1:0]   sum5_q;

  always_ff @(posedge clk_i) begin
    if (en5) begin
      iprod5_q <= $signed({1'b0, integ_gain_q}) * integ4_q;
      pd5_q    <= PD_W'(pprod4_q) + PD_W'(dprod4_q);
      sum5_q   <= sum4_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: final add, arithmetic shift (floor), clamp, output register.
  // ---------------------------------------------------------------------------
  logic signed [TOTAL_W-1:0]            total;
  logic signed [TOTAL_W-FRAC_SHIFT-1:0] shifted;
  logic signed [POWER_W-1:0]            power;

  assign total   = TOTAL_W'(pd5_q) + TOTAL_W'(iprod5_q);
  assign shifted = total[TOTAL_W-1:FRAC_SHIFT];

  always_comb begin
    if (shifted > PWR_HI) begin
      power = POWER_W'(PWR_HI);
    end else if (shifted < PWR_LO) begin
      power = POWER_W'(PWR_LO);
    end else begin
      power = shifted[POWER_W-1:0];
    end
  end

  logic signed [POWER_W-1:0] power_q;
  logic signed [SUM_W-1:0]   wsum_q;

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      power_q <= power;
      wsum_q  <= sum5_q;
    end
  end

  assign out_valid_o   = vo_q;
  assign motor_power_o = power_q;
  assign window_sum_o  = wsum_q;

endmodule

>>> bench/power_checker.sv
`timescale 1ns / 1ps

module power_checker #(
  parameter int unsigned WINDOW = wsp_pkg::WINDOW_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [wsp_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [wsp_pkg::CFG_DAT_W-1:0]        cfg_data_i,
  input  logic                                 in_valid_i,
  input  logic                                 in_ready_i,
  input  logic signed [wsp_pkg::DELTA_W-1:0]   encoder_delta_i,
  input  logic                                 out_valid_i,
  input  logic                                 out_ready_i,
  input  logic signed [wsp_pkg::POWER_W-1:0]   motor_power_i,
  input  logic signed [wsp_pkg::SUM_W-1:0]     window_sum_i,
  output int unsigned                          fail_count_o,
  output int unsigned                          pending_o
);
  import wsp_pkg::*;

  typedef struct packed {
    logic signed [POWER_W-1:0] power;
    logic signed [SUM_W-1:0]   sum;
  } power_beat_t;

  power_beat_t               power_due_q[$];
  logic signed [DELTA_W-1:0] ring_mem [WINDOW];
  int unsigned               newest_pos;
  logic signed [SUM_W-1:0]   speed_sum;
  longint                    integ_state;
  logic [GAIN_W-1:0]         kp, ki, kd;
  logic signed [SUM_W-1:0]   speed_target;
  logic                      bypass_on;

  // Advances the window by one delta and, unless bypass is on, queues the power beat it should produce.
  task automatic predict_power(input logic signed [DELTA_W-1:0] delta);
    longint      speed_err;
    longint      drive;
    power_beat_t beat;
    newest_pos = (newest_pos + 1) % WINDOW;
    speed_sum = speed_sum - ring_mem[newest_pos] + delta;
    ring_mem[newest_pos] = delta;
    if (bypass_on) return;
    speed_err = longint'(speed_sum) - longint'(speed_target);
    integ_state = integ_state + speed_err;
    if (integ_state > INTEG_LIMIT) integ_state = INTEG_LIMIT;
    else if (integ_state < -INTEG_LIMIT) integ_state = -INTEG_LIMIT;
    drive = (longint'(kp) * speed_err + longint'(ki) * integ_state
             + longint'(kd) * longint'(delta)) >>> FRAC_SHIFT;
    if (drive > POWER_LIMIT) drive = POWER_LIMIT;
    else if (drive < -POWER_LIMIT) drive = -POWER_LIMIT;
    beat.power = drive[POWER_W-1:0];
    beat.sum   = speed_sum;
    power_due_q.push_back(beat);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    power_beat_t due;
    if (!rst_ni) begin
      for (int k = 0; k < WINDOW; k++) ring_mem[k] = '0;
      newest_pos   = 0;
      speed_sum    = '0;
      integ_state  = 0;
      kp           = PROP_GAIN_RST;
      ki           = INTEG_GAIN_RST;
      kd           = DERIV_GAIN_RST;
      speed_target = '0;
      bypass_on    = 1'b0;
      fail_count_o = 0;
      power_due_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (power_due_q.size() == 0) begin
          $error("power beat with nothing expected: motor_power %0d, window_sum %0d",
                 motor_power_i, window_sum_i);
          fail_count_o++;
        end else begin
          due = power_due_q.pop_front();
          if (motor_power_i !== due.power) begin
            $error("motor_power: expected %0d, actual %0d", due.power, motor_power_i);
            fail_count_o++;
          end
          if (window_sum_i !== due.sum) begin
            $error("window_sum: expected %0d, actual %0d", due.sum, window_sum_i);
            fail_count_o++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_PROP_GAIN:  kp = cfg_data_i[GAIN_W-1:0];
          REG_INTEG_GAIN: ki = cfg_data_i[GAIN_W-1:0];
          REG_DERIV_GAIN: kd = cfg_data_i[GAIN_W-1:0];
          REG_TARGET_SUM: begin
            speed_target = cfg_data_i;
            integ_state  = 0;
          end
          REG_BYPASS:     bypass_on = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) predict_power(encoder_delta_i);
    end
    pending_o = power_due_q.size();
  end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import wsp_pkg::*;

  // Indexes past the end of the register map; writes there must change nothing.
  localparam int unsigned REG_SPARE_LO = 5;
  localparam int unsigned REG_SPARE_HI = 7;

  // Cycles allowed after the last expected beat, since a beat taken in bypass may still
  // be moving through the pipeline.
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned PHASES       = 10;
  localparam int unsigned PHASE_BEATS  = 95;
  localparam int unsigned IDLE_PCT     = 14;

  logic                      clk_i           = 1'b0;
  logic                      rst_ni          = 1'b0;
  logic                      cfg_we_i        = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_idx_i       = '0;
  logic [CFG_DAT_W-1:0]      cfg_data_i      = '0;
  logic                      in_valid_i      = 1'b0;
  logic signed [DELTA_W-1:0] encoder_delta_i = '0;
  logic                      out_ready_i     = 1'b0;
  logic                      in_ready_o;
  logic                      out_valid_o;
  logic signed [POWER_W-1:0] motor_power_o;
  logic signed [SUM_W-1:0]   window_sum_o;

  int unsigned fail_count;
  int unsigned pending;

  // While set, neither the delta source nor the power sink inserts idle cycles.
  bit steady_run = 1'b0;

  windowed_speed_pid DUT (.*);

  power_checker u_power_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .encoder_delta_i (encoder_delta_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .motor_power_i   (motor_power_o),
    .window_sum_i    (window_sum_o),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // The power sink stalls on roughly one cycle in seven, except during the steady phase.
  always @(negedge clk_i) begin
    out_ready_i <= steady_run || ($urandom_range(99) >= IDLE_PCT);
  end

  // Presents one delta beat, possibly after a few idle cycles, and returns once it is taken.
  // Valid is left high, so back-to-back calls keep the channel busy without a bubble.
  task automatic send_delta(input logic [DELTA_W-1:0] delta);
    @(negedge clk_i);
    while (!steady_run && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    encoder_delta_i <= delta;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Stops the source and waits until every expected power beat has come out, then gives
  // the pipeline time to flush any beats taken in bypass.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DAT_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Gains lean toward small values so that the power is not always pinned at the clamp,
  // with the two extremes showing up regularly.
  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2:       return GAIN_W'($urandom);
      default: return GAIN_W'($urandom_range(24));
    endcase
  endfunction

  // Most deltas are small, like a motor near its set speed; some span the full field.
  function automatic logic [DELTA_W-1:0] pick_delta();
    case ($urandom_range(9))
      0:       return DELTA_W'($urandom);
      1, 2:    return DELTA_W'($urandom_range(1024) - 512);
      default: return DELTA_W'($urandom_range(64) - 32);
    endcase
  endfunction

  initial begin : stimulus
    logic [CFG_DAT_W-1:0] target;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // With the reset gains, a window full of the largest delta pushes the sum to 16376,
    // winds the integrator into its limit and pins the power high; the most negative delta
    // then swings everything the other way.
    repeat (8) send_delta(12'h7FF);
    repeat (8) send_delta(12'h800);
    send_delta(12'h000);
    send_delta(12'hFFF);
    send_delta(12'h555);
    send_delta(12'hAAA);
    settle();

    // All gains at full scale against the extreme targets: the error needs all 17 bits.
    write_reg(REG_PROP_GAIN, 16'h00FF);
    write_reg(REG_INTEG_GAIN, 16'h00FF);
    write_reg(REG_DERIV_GAIN, 16'h00FF);
    write_reg(REG_TARGET_SUM, 16'h7FFF);
    send_delta(12'h7FF);
    send_delta(12'h800);
    send_delta(12'h000);
    settle();
    write_reg(REG_TARGET_SUM, 16'h8000);
    send_delta(12'h7FF);
    send_delta(12'h000);
    settle();

    // Rewriting the same target still clears the integrator, and writes to the unused
    // indexes must leave every register alone.
    write_reg(REG_TARGET_SUM, 16'h8000);
    for (int idx = REG_SPARE_LO; idx <= REG_SPARE_HI; idx++) begin
      write_reg(CFG_IDX_W'(idx), 16'hFFFF);
    end
    send_delta(12'h001);
    settle();

    // In bypass the window keeps moving but no power beat comes out; the sum reported
    // after bypass is lifted must include the deltas taken meanwhile. Only bit 0 counts.
    write_reg(REG_BYPASS, 16'h0001);
    repeat (3) send_delta(pick_delta());
    settle();
    write_reg(REG_BYPASS, 16'hFFFE);
    send_delta(12'h123);
    send_delta(12'hEDC);

    // Random phases. Each one starts from an idle block with fresh settings; the upper
    // data bits of the narrow registers carry junk that the block must drop.
    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_reg(REG_PROP_GAIN, {8'($urandom), pick_gain()});
      write_reg(REG_INTEG_GAIN, {8'($urandom), pick_gain()});
      write_reg(REG_DERIV_GAIN, {8'($urandom), pick_gain()});
      case ($urandom_range(5))
        0:       target = 16'h7FFF;
        1:       target = 16'h8000;
        2:       target = 16'($urandom);
        default: target = 16'($urandom_range(400) - 200);
      endcase
      write_reg(REG_TARGET_SUM, target);
      if ($urandom_range(4) == 0) begin
        write_reg(REG_BYPASS, 16'($urandom) | 16'h0001);
        repeat (12) send_delta(pick_delta());
        settle();
      end
      write_reg(REG_BYPASS, 16'($urandom) & 16'hFFFE);
      // One phase in the middle runs with no idle cycles on either side.
      steady_run <= (p == PHASES / 2);
      repeat (PHASE_BEATS) send_delta(pick_delta());
    end

    settle();
    if (fail_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // A hung handshake or a power beat that never arrives ends the run here.
  initial begin : watchdog
    #2_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
